@@ design/ipv4fhg_pkg.sv @@
package ipv4fhg_pkg;

    localparam int DEF_MTU   = 1500;
    localparam int HDR_BYTES = 20;
    localparam int MAX_FRAGS = 45;
    localparam int FRAG_CNT_W = $clog2(MAX_FRAGS);

    localparam logic [7:0]  TTL_RESET = 8'd64;
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;

    localparam logic REG_LOCAL_IP = 1'b0;
    localparam logic REG_TTL      = 1'b1;

    typedef struct packed {
        logic load;
        logic base;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic final_frag;
    } t_status;

endpackage

@@ design/ipv4fhg_ctrl.sv @@
module ipv4fhg_ctrl
    import ipv4fhg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       emit_ok;

    assign emit_ok = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BASE;
                end
            end
            ST_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.final_frag) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/ipv4fhg_dp.sv @@
module ipv4fhg_dp
    import ipv4fhg_pkg::*;
#(
    parameter int MTU = DEF_MTU
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [31:0] i_local_ip,
    input  logic [7:0]  i_ttl,
    input  logic [15:0] i_payload_len,
    input  logic [31:0] i_dst_ip,
    input  logic [7:0]  i_protocol,
    output logic [10:0] o_total_len,
    output logic [15:0] o_ident,
    output logic        o_more_fragments,
    output logic [12:0] o_frag_offset,
    output logic [15:0] o_header_checksum,
    output logic [31:0] o_dest_addr,
    output logic [7:0]  o_proto_out,
    output logic        o_last
);

    localparam logic [15:0] FRAG_BYTES = 16'((MTU - HDR_BYTES) & ~7);
    localparam logic [FRAG_CNT_W-1:0] LAST_K = FRAG_CNT_W'(MAX_FRAGS - 1);

    logic [15:0]           r_next_ident;
    logic [15:0]           r_id;
    logic [15:0]           r_rem;
    logic [15:0]           r_off;
    logic [FRAG_CNT_W-1:0] r_k;
    logic [31:0]           r_dst;
    logic [7:0]            r_proto;
    logic [15:0]           r_base;

    logic [10:0] r_total_len;
    logic [15:0] r_ident;
    logic        r_mf;
    logic [12:0] r_frag_offset;
    logic [15:0] r_csum;
    logic [31:0] r_dest_addr;
    logic [7:0]  r_proto_out;
    logic        r_last;

    logic        fits;
    logic        final_frag;
    logic [15:0] size;
    logic [15:0] tlen;
    logic [15:0] flagoff;
    logic [18:0] base_sum;
    logic [16:0] base_f1;
    logic [16:0] base_f2;
    logic [17:0] frag_sum;
    logic [16:0] frag_f1;
    logic [16:0] frag_f2;

    assign fits       = (r_rem <= FRAG_BYTES);
    assign final_frag = fits || (r_k == LAST_K);
    assign size       = fits ? r_rem : FRAG_BYTES;
    assign tlen       = 16'(HDR_BYTES) + size;
    assign flagoff    = {2'b00, !final_frag, r_off[15:3]};

    // partial sum of the words that stay fixed over a datagram
    assign base_sum = 19'(VER_IHL_TOS) + 19'(r_id) + 19'({i_ttl, r_proto})
                    + 19'(i_local_ip[31:16]) + 19'(i_local_ip[15:0])
                    + 19'(r_dst[31:16]) + 19'(r_dst[15:0]);
    assign base_f1  = 17'(base_sum[15:0]) + 17'(base_sum[18:16]);
    assign base_f2  = 17'(base_f1[15:0]) + 17'(base_f1[16]);

    assign frag_sum = 18'(r_base) + 18'(tlen) + 18'(flagoff);
    assign frag_f1  = 17'(frag_sum[15:0]) + 17'(frag_sum[17:16]);
    assign frag_f2  = 17'(frag_f1[15:0]) + 17'(frag_f1[16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_ident <= '0;
        end else if (i_cmd.load) begin
            r_next_ident <= r_next_ident + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id    <= r_next_ident;
            r_rem   <= i_payload_len;
            r_off   <= '0;
            r_k     <= '0;
            r_dst   <= i_dst_ip;
            r_proto <= i_protocol;
        end
        if (i_cmd.base) begin
            r_base <= base_f2[15:0];
        end
        if (i_cmd.emit) begin
            r_rem         <= r_rem - size;
            r_off         <= r_off + size;
            r_k           <= r_k + 1'b1;
            r_total_len   <= tlen[10:0];
            r_ident       <= r_id;
            r_mf          <= !final_frag;
            r_frag_offset <= r_off[15:3];
            r_csum        <= ~frag_f2[15:0];
            r_dest_addr   <= r_dst;
            r_proto_out   <= r_proto;
            r_last        <= final_frag;
        end
    end

    assign o_status.final_frag = final_frag;
    assign o_total_len         = r_total_len;
    assign o_ident             = r_ident;
    assign o_more_fragments    = r_mf;
    assign o_frag_offset       = r_frag_offset;
    assign o_header_checksum   = r_csum;
    assign o_dest_addr         = r_dest_addr;
    assign o_proto_out         = r_proto_out;
    assign o_last              = r_last;

endmodule

@@ design/ipv4_tx_fragment_header_gen_core.sv @@
// ipv4 transmit fragment header generator
// input channel (i_in_valid / o_in_stall): one transaction per datagram with
// payload length, destination address and protocol
// output channel (o_out_valid / i_out_stall): one transaction per fragment
// header, o_out_last set on the final fragment of the datagram
// apb port: local_ip at byte address 0, time_to_live at byte address 4
// a datagram of k fragments (1 to 45) occupies the block for an accept state,
// a state to sum the words fixed for the datagram, then one fragment header
// per cycle from the checksum and split unit while the receiver does not stall
// the first header is registered into the output register after the accept and base states
// o_in_stall stays high until the last header is loaded into the output register
// a stalled receiver holds the output register and pauses fragment generation
// reset clears the identification counter to zero, local_ip to zero,
// time_to_live to 64 and drops any datagram in progress
module ipv4_tx_fragment_header_gen_core
    import ipv4fhg_pkg::*;
#(
    parameter int MTU = DEF_MTU
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_in_payload_len,
    input  logic [31:0] i_in_dst_ip,
    input  logic [7:0]  i_in_protocol,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_out_total_len,
    output logic [15:0] o_out_ident,
    output logic        o_out_more_fragments,
    output logic [12:0] o_out_frag_offset,
    output logic [15:0] o_out_header_checksum,
    output logic [31:0] o_out_dest_addr,
    output logic [7:0]  o_out_proto_out,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_local_ip;
    logic [7:0]  r_ttl;
    logic        cfg_wr;
    t_cmd        cmd;
    t_status     status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
            r_ttl      <= TTL_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LOCAL_IP: r_local_ip <= pwdata;
                REG_TTL:      r_ttl      <= pwdata[7:0];
                default:      r_ttl      <= r_ttl;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_TTL) ? {24'd0, r_ttl} : r_local_ip;

    ipv4fhg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ipv4fhg_dp #(
        .MTU (MTU)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_local_ip        (r_local_ip),
        .i_ttl             (r_ttl),
        .i_payload_len     (i_in_payload_len),
        .i_dst_ip          (i_in_dst_ip),
        .i_protocol        (i_in_protocol),
        .o_total_len       (o_out_total_len),
        .o_ident           (o_out_ident),
        .o_more_fragments  (o_out_more_fragments),
        .o_frag_offset     (o_out_frag_offset),
        .o_header_checksum (o_out_header_checksum),
        .o_dest_addr       (o_out_dest_addr),
        .o_proto_out       (o_out_proto_out),
        .o_last            (o_out_last)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after datagram accept");

    a_last_vs_mf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_last != o_out_more_fragments))
        else $error("last and more_fragments disagree");

    a_next_frag_same_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_last)
        |=> (o_out_valid && o_out_ident == $past(o_out_ident)))
        else $error("fragment sequence broken");

endmodule

@@ test/ipv4_tx_fragment_header_gen_core_test.sv @@
`timescale 1ns / 1ps

module ipv4_tx_fragment_header_gen_core_test
    import ipv4fhg_pkg::*;
();

    localparam int FRAG_BYTES    = (DEF_MTU - HDR_BYTES) & ~7;
    localparam int RAND_PER_SET  = 25;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic [10:0] total_len;
        logic [15:0] ident;
        logic        more_fragments;
        logic [12:0] frag_offset;
        logic [15:0] header_checksum;
        logic [31:0] dest_addr;
        logic [7:0]  proto_out;
        logic        last;
    } t_hdr;

    // frags of zero: shape not typed in, predictor only
    typedef struct packed {
        logic [5:0]  frags;
        logic [10:0] last_len;
    } t_shape;

    typedef struct packed {
        logic [15:0] len;
        logic [31:0] dst;
        logic [7:0]  proto;
        t_shape      shape;
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    localparam int DIR_ROWS = 14;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{16'd0,     32'h0000_0000, 8'h00, '{6'd1,  11'd20}},
        '{16'd1,     32'hFFFF_FFFF, 8'hFF, '{6'd1,  11'd21}},
        '{16'd8,     32'h0102_0304, 8'h11, '{6'd1,  11'd28}},
        '{16'd1479,  32'hC0A8_0001, 8'h06, '{6'd1,  11'd1499}},
        '{16'd1480,  32'h0A00_0001, 8'h11, '{6'd1,  11'd1500}},
        '{16'd1481,  32'h7FFF_FFFF, 8'h01, '{6'd2,  11'd21}},
        '{16'd2960,  32'h8000_0000, 8'h80, '{6'd2,  11'd1500}},
        '{16'd3000,  32'hAAAA_5555, 8'h55, '{6'd3,  11'd60}},
        '{16'h5555,  32'h5555_AAAA, 8'hAA, '{6'd15, 11'd1145}},
        '{16'hAAAA,  32'hDEAD_BEEF, 8'h2F, '{6'd30, 11'd790}},
        '{16'd65515, 32'hFFFF_0000, 8'h7F, '{6'd45, 11'd415}},
        '{16'd65535, 32'h0000_FFFF, 8'hFE, '{6'd45, 11'd435}},
        '{16'd100,   32'hC0A8_0001, 8'h11, '{6'd0,  11'd0}},
        '{16'd7,     32'h8000_0001, 8'h80, '{6'd0,  11'd0}}
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_in_payload_len = '0;
    logic [31:0] i_in_dst_ip = '0;
    logic [7:0]  i_in_protocol = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [10:0] o_out_total_len;
    logic [15:0] o_out_ident;
    logic        o_out_more_fragments;
    logic [12:0] o_out_frag_offset;
    logic [15:0] o_out_header_checksum;
    logic [31:0] o_out_dest_addr;
    logic [7:0]  o_out_proto_out;
    logic        o_out_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_shape      drv_shape = '0;

    logic [31:0] cfg_local_ip = '0;
    logic [7:0]  cfg_ttl = TTL_RESET;
    logic [15:0] dgram_ident = '0;

    t_hdr        pending_hdrs[$];
    t_shape      pending_shapes[$];
    int          frags_seen = 0;
    int          n_errors = 0;
    int          n_dgrams = 0;
    int          n_hdrs = 0;
    int          idle_cycles = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    logic [7:0]  stall_tick = '0;

    ipv4_tx_fragment_header_gen_core i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_payload_len      (i_in_payload_len),
        .i_in_dst_ip           (i_in_dst_ip),
        .i_in_protocol         (i_in_protocol),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_total_len       (o_out_total_len),
        .o_out_ident           (o_out_ident),
        .o_out_more_fragments  (o_out_more_fragments),
        .o_out_frag_offset     (o_out_frag_offset),
        .o_out_header_checksum (o_out_header_checksum),
        .o_out_dest_addr       (o_out_dest_addr),
        .o_out_proto_out       (o_out_proto_out),
        .o_out_last            (o_out_last),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = acc + word;
        return s[15:0] + 16'(s[16]);
    endfunction

    function automatic logic [15:0] header_sum(input logic [15:0] tlen, input logic [15:0] id,
                                               input logic [15:0] flag_off,
                                               input logic [7:0] proto, input logic [31:0] dst);
        logic [15:0] s;
        s = ones_add(16'h0, VER_IHL_TOS);
        s = ones_add(s, tlen);
        s = ones_add(s, id);
        s = ones_add(s, flag_off);
        s = ones_add(s, {cfg_ttl, proto});
        s = ones_add(s, 16'h0);
        s = ones_add(s, cfg_local_ip[31:16]);
        s = ones_add(s, cfg_local_ip[15:0]);
        s = ones_add(s, dst[31:16]);
        s = ones_add(s, dst[15:0]);
        return ~s;
    endfunction

    task automatic split_datagram(input logic [15:0] len, input logic [31:0] dst,
                                  input logic [7:0] proto);
        int unsigned rem;
        int unsigned off;
        int unsigned size;
        int          k;
        logic        fin;
        logic [15:0] tlen;
        logic [12:0] off_units;
        t_hdr        h;
        rem = len;
        off = 0;
        fin = 1'b0;
        for (k = 0; k < MAX_FRAGS && !fin; k++) begin
            fin = (rem <= FRAG_BYTES) || (k == MAX_FRAGS - 1);
            size = (rem <= FRAG_BYTES) ? rem : FRAG_BYTES;
            tlen = 16'(HDR_BYTES + size);
            off_units = 13'(off >> 3);
            h.total_len = tlen[10:0];
            h.ident = dgram_ident;
            h.more_fragments = ~fin;
            h.frag_offset = off_units;
            h.header_checksum = header_sum(tlen, dgram_ident, {2'b00, ~fin, off_units},
                                           proto, dst);
            h.dest_addr = dst;
            h.proto_out = proto;
            h.last = fin;
            pending_hdrs.push_back(h);
            rem -= size;
            off += size;
        end
        dgram_ident = dgram_ident + 16'd1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // receiver stall pattern, changes mode at random intervals
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= stall_tick[2];
            end
        endcase
    end

    // prediction on input transactions, checking on output transactions, watchdog
    always @(posedge i_clk) begin
        t_hdr   want;
        t_shape shp;
        logic   moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                split_datagram(i_in_payload_len, i_in_dst_ip, i_in_protocol);
                pending_shapes.push_back(drv_shape);
                n_dgrams++;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                n_hdrs++;
                frags_seen++;
                if (pending_hdrs.size() == 0) begin
                    $error("fragment header with none pending");
                    n_errors++;
                end else begin
                    want = pending_hdrs.pop_front();
                    check_field("total_len", want.total_len, o_out_total_len);
                    check_field("ident", want.ident, o_out_ident);
                    check_field("more_fragments", want.more_fragments, o_out_more_fragments);
                    check_field("frag_offset", want.frag_offset, o_out_frag_offset);
                    check_field("header_checksum", want.header_checksum,
                                o_out_header_checksum);
                    check_field("dest_addr", want.dest_addr, o_out_dest_addr);
                    check_field("proto_out", want.proto_out, o_out_proto_out);
                    check_field("last", want.last, o_out_last);
                end
                if (o_out_last) begin
                    if (pending_shapes.size() != 0) begin
                        shp = pending_shapes.pop_front();
                        if (shp.frags != 0) begin
                            check_field("fragment count", shp.frags, frags_seen);
                            check_field("last total_len", shp.last_len, o_out_total_len);
                        end
                    end
                    frags_seen = 0;
                end
            end
            if (psel && penable && pready) begin
                moved = 1'b1;
            end
        end
        if (moved) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[ipv4_tx_fragment_header_gen_core] ERROR");
            $finish;
        end
    end

    task automatic send_datagram(input logic [15:0] len, input logic [31:0] dst,
                                 input logic [7:0] proto, input t_shape shape);
        i_in_valid <= 1'b1;
        i_in_payload_len <= len;
        i_in_dst_ip <= dst;
        i_in_protocol <= proto;
        drv_shape <= shape;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_all_headers();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hdrs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_LOCAL_IP) begin
            cfg_local_ip = data;
        end else begin
            cfg_ttl = data[7:0];
        end
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] set_ip  [4];
        logic [7:0]  set_ttl [4];
        logic [15:0] len;
        int          burst;
        int          gap;
        int          n;
        set_ip  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), $urandom()};
        set_ttl = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers first
        for (n = 0; n < DIR_ROWS; n++) begin
            send_datagram(DIR_TABLE[n].len, DIR_TABLE[n].dst, DIR_TABLE[n].proto,
                          DIR_TABLE[n].shape);
        end
        wait_all_headers();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_LOCAL_IP, set_ip[ph]);
            write_reg(REG_TTL, {24'h0, set_ttl[ph]});
            @(posedge i_clk);
            burst = $urandom_range(1, 10);
            for (n = 0; n < RAND_PER_SET; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: len = 16'($urandom_range(0, 3 * FRAG_BYTES));
                    4, 5: len = 16'(FRAG_BYTES * $urandom_range(1, 4));
                    6: len = 16'(FRAG_BYTES * $urandom_range(1, 4) + $urandom_range(0, 2) - 1);
                    7: len = 16'($urandom_range(0, 40));
                    8: len = 16'($urandom());
                    default: len = 16'($urandom_range(FRAG_BYTES - 8, FRAG_BYTES + 8));
                endcase
                send_datagram(len, $urandom(), 8'($urandom_range(0, 255)), '0);
                if (ph == 2 && n == RAND_PER_SET / 2) begin
                    // hold off until the block has drained completely
                    wait_all_headers();
                end else begin
                    burst--;
                    if (burst == 0) begin
                        burst = $urandom_range(1, 10);
                        gap = $urandom_range(0, 6);
                        if (gap != 0) begin
                            i_in_valid <= 1'b0;
                            repeat (gap) @(posedge i_clk);
                        end
                    end
                end
            end
            wait_all_headers();
        end

        if (pending_hdrs.size() != 0) begin
            $error("%0d fragment headers never arrived", pending_hdrs.size());
            n_errors++;
        end
        $display("covered %0d datagrams and %0d fragment headers under five register settings,",
                 n_dgrams, n_hdrs);
        $display("including ttl and source address extremes, exact multiples and 45-fragment splits");
        if (n_errors == 0) begin
            $display("[ipv4_tx_fragment_header_gen_core] OK");
        end else begin
            $display("[ipv4_tx_fragment_header_gen_core] ERROR");
        end
        $finish;
    end

endmodule
